// ===== hdl/spq_pkg.sv =====
// Shared types, codes and constants of the sorted priority queue.
package spq_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DataW     = 32;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned PosW      = 4;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned StatusW   = 2;

  // Default number of stored entries.
  localparam int unsigned DefaultCapacity = 16;

  // Request commands; the fourth code changes nothing and returns an OK result.
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } spq_cmd_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } spq_status_e;

  // Memory write selection.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW_ABOVE,
    WR_NEW_FIRST
  } spq_wr_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_K,
    S_COMPARE,
    S_PUT_FIRST,
    S_FETCH,
    S_DELIVER
  } spq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;
    logic        idx_tail;
    logic        idx_pos;
    logic        idx_dec;
    logic        mem_rd;
    spq_wr_e     wr_mode;
    logic        cnt_inc;
    logic        cnt_dec;
    logic        res_load;
    logic        res_data;
    spq_status_e res_status;
  } spq_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    spq_cmd_e cmd;
    logic     empty;
    logic     full;
    logic     pos_bad;
    logic     greater;
    logic     idx_zero;
    logic     out_busy;
  } spq_flags_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// Controller state machine that sequences insert, delete and read requests.
module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spq_pkg::spq_flags_t flags_i,
  output spq_pkg::spq_ctrl_t  ctrl_o
);

  spq_pkg::spq_state_e state_q, state_d;

  // A request is taken only when idle and the result register can be refilled.
  assign in_stall_o = (state_q != spq_pkg::S_IDLE) || flags_i.out_busy;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d           = state_q;
    ctrl_o            = '0;
    ctrl_o.wr_mode    = spq_pkg::WR_NONE;
    ctrl_o.res_status = spq_pkg::ST_OK;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          ctrl_o.load = 1'b1;
          state_d     = spq_pkg::S_DECODE;
        end
      end
      spq_pkg::S_DECODE: begin
        state_d = spq_pkg::S_IDLE;
        case (flags_i.cmd)
          spq_pkg::CMD_INSERT: begin
            if (flags_i.full) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = spq_pkg::ST_FULL;
            end else if (flags_i.empty) begin
              ctrl_o.wr_mode  = spq_pkg::WR_NEW_FIRST;
              ctrl_o.cnt_inc  = 1'b1;
              ctrl_o.res_load = 1'b1;
            end else begin
              ctrl_o.idx_tail = 1'b1;
              state_d         = spq_pkg::S_READ_K;
            end
          end
          spq_pkg::CMD_DELETE: begin
            if (flags_i.empty) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = spq_pkg::ST_EMPTY;
            end else begin
              ctrl_o.idx_tail = 1'b1;
              ctrl_o.cnt_dec  = 1'b1;
              state_d         = spq_pkg::S_FETCH;
            end
          end
          spq_pkg::CMD_READ: begin
            if (flags_i.empty) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = spq_pkg::ST_EMPTY;
            end else if (flags_i.pos_bad) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = spq_pkg::ST_RANGE;
            end else begin
              ctrl_o.idx_pos = 1'b1;
              state_d        = spq_pkg::S_FETCH;
            end
          end
          default: begin
            ctrl_o.res_load = 1'b1;
          end
        endcase
      end
      // Insert: walk from the tail, shifting smaller or equal entries up by one.
      spq_pkg::S_READ_K: begin
        ctrl_o.mem_rd = 1'b1;
        state_d       = spq_pkg::S_COMPARE;
      end
      spq_pkg::S_COMPARE: begin
        if (flags_i.greater) begin
          ctrl_o.wr_mode  = spq_pkg::WR_NEW_ABOVE;
          ctrl_o.cnt_inc  = 1'b1;
          ctrl_o.res_load = 1'b1;
          state_d         = spq_pkg::S_IDLE;
        end else begin
          ctrl_o.wr_mode = spq_pkg::WR_SHIFT;
          if (flags_i.idx_zero) begin
            state_d = spq_pkg::S_PUT_FIRST;
          end else begin
            ctrl_o.idx_dec = 1'b1;
            state_d        = spq_pkg::S_READ_K;
          end
        end
      end
      spq_pkg::S_PUT_FIRST: begin
        ctrl_o.wr_mode  = spq_pkg::WR_NEW_FIRST;
        ctrl_o.cnt_inc  = 1'b1;
        ctrl_o.res_load = 1'b1;
        state_d         = spq_pkg::S_IDLE;
      end
      // Delete and read: one memory read, then the result.
      spq_pkg::S_FETCH: begin
        ctrl_o.mem_rd = 1'b1;
        state_d       = spq_pkg::S_DELIVER;
      end
      spq_pkg::S_DELIVER: begin
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_data = 1'b1;
        state_d         = spq_pkg::S_IDLE;
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/spq_dpath.sv =====
// Datapath of the sorted priority queue: entry memory, count, index and result register.
module spq_dpath #(
  parameter int unsigned CAPACITY = spq_pkg::DefaultCapacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic        [spq_pkg::CmdW-1:0]     command_i,
  input  logic signed [spq_pkg::DataW-1:0]    value_i,
  input  logic        [spq_pkg::PosW-1:0]     position_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [spq_pkg::DataW-1:0]    entry_value_o,
  output logic        [spq_pkg::CountOutW-1:0] entry_count_o,
  output logic        [spq_pkg::StatusW-1:0]  status_o,
  input  spq_pkg::spq_ctrl_t                  ctrl_i,
  output spq_pkg::spq_flags_t                 flags_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > spq_pkg::PosW) ? CW : spq_pkg::PosW;

  logic signed [spq_pkg::DataW-1:0] mem_q [CAPACITY];

  logic        [CW-1:0]                 count_q, count_d;
  logic        [AW-1:0]                 idx_q;
  logic        [AW-1:0]                 idx_up;
  logic        [spq_pkg::CmdW-1:0]      cmd_q;
  logic        [spq_pkg::PosW-1:0]      pos_q;
  logic signed [spq_pkg::DataW-1:0]     val_q;
  logic signed [spq_pkg::DataW-1:0]     rdata_q;
  logic                                 out_valid_q;
  logic signed [spq_pkg::DataW-1:0]     res_value_q;
  logic        [spq_pkg::CountOutW-1:0] res_count_q;
  spq_pkg::spq_status_e                 res_status_q;

  logic                                 wr_en;
  logic        [AW-1:0]                 wr_addr;
  logic signed [spq_pkg::DataW-1:0]     wr_data;

  assign idx_up = idx_q + AW'(1);

  // Status toward the controller.
  always_comb begin
    flags_o          = '0;
    flags_o.cmd      = spq_pkg::spq_cmd_e'(cmd_q);
    flags_o.empty    = (count_q == '0);
    flags_o.full     = (count_q >= CW'(CAPACITY));
    flags_o.pos_bad  = (CMPW'(pos_q) >= CMPW'(count_q));
    flags_o.greater  = (rdata_q > val_q);
    flags_o.idx_zero = (idx_q == '0);
    flags_o.out_busy = out_valid_q && out_stall_i;
  end

  // Captured request fields.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= command_i;
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  // Entry index used for memory reads and shifts.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.idx_tail) begin
      idx_q <= AW'(count_q - CW'(1));
    end else if (ctrl_i.idx_pos) begin
      idx_q <= AW'(pos_q);
    end else if (ctrl_i.idx_dec) begin
      idx_q <= idx_q - AW'(1);
    end
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (ctrl_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (ctrl_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Memory write port selection.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_up;
    wr_data = val_q;
    case (ctrl_i.wr_mode)
      spq_pkg::WR_SHIFT: begin
        wr_data = rdata_q;
      end
      spq_pkg::WR_NEW_ABOVE: begin
        wr_data = val_q;
      end
      spq_pkg::WR_NEW_FIRST: begin
        wr_addr = '0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.mem_rd) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  // Result register, refilled only when the previous result is gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      res_value_q  <= ctrl_i.res_data ? rdata_q : '0;
      res_count_q  <= spq_pkg::CountOutW'(count_d);
      res_status_q <= ctrl_i.res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = res_value_q;
  assign entry_count_o = res_count_q;
  assign status_o      = res_status_q;

  // The count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // An insert never lands in a full store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cnt_inc |-> (count_q < CW'(CAPACITY)))
    else $error("insert into full store");

  // A shift or placement above the index stays inside the memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.wr_mode == spq_pkg::WR_SHIFT || ctrl_i.wr_mode == spq_pkg::WR_NEW_ABOVE)
      |-> (CW'(idx_q) < CW'(CAPACITY - 1)))
    else $error("shift beyond last entry");

  // A new result never overwrites one that is still held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.res_load |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // Count changes only in a cycle that loads a result or makes no memory read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cnt_inc || ctrl_i.cnt_dec) |-> (ctrl_i.res_load || ctrl_i.mem_rd == 1'b0))
    else $error("count change without request completion");

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: controller and datapath.
//
// A bounded store of signed 32-bit values kept in descending order.
// Input channel (in_valid_i / in_stall_o) carries a request: command_i
// selects insert of value_i, delete of the smallest entry, or read of the
// entry at position_i (0 is the largest). Output channel (out_valid_o /
// out_stall_i) returns one result per request: entry_value_o, the count
// after the request in entry_count_o, and status_o.
// Requests are handled one at a time. A rejected request, an unknown
// command or an insert into an empty store delivers its result from the
// decode state; a read or a delete goes on through a fetch and a deliver
// state. An insert that moves m entries up walks the entry memory from the
// tail through its single read and write port, then places the new value.
// The next request is taken once the controller is idle again and the
// output register is empty or its result is taken in that same cycle;
// while the receiver stalls a result, the result holds and the input stalls.
// Reset empties the store at once; no clearing pass is needed since only
// entries below the count are ever read.
module sorted_priority_queue_core #(
  parameter int unsigned CAPACITY = spq_pkg::DefaultCapacity
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [spq_pkg::CmdW-1:0]      command_i,
  input  logic signed [spq_pkg::DataW-1:0]     value_i,
  input  logic        [spq_pkg::PosW-1:0]      position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [spq_pkg::DataW-1:0]     entry_value_o,
  output logic        [spq_pkg::CountOutW-1:0] entry_count_o,
  output logic        [spq_pkg::StatusW-1:0]   status_o
);

  spq_pkg::spq_ctrl_t  ctrl;
  spq_pkg::spq_flags_t flags;

  // Request sequencing.
  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  // Storage and result path.
  spq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (command_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_value_o (entry_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o),
    .ctrl_i        (ctrl),
    .flags_o       (flags)
  );

endmodule
